// ===== design/sfa_pkg.sv =====
// Shared types, widths, register codes and reciprocal table for the spectrum frame averager.
package sfa_pkg;

   localparam int HALF_BINS_DEF      = 512;
   localparam int HISTORY_FRAMES_DEF = 4;
   localparam int FIFO_DEPTH_DEF     = 4;

   localparam int SAMPLE_W    = 16;
   localparam int BIN_OUT_W   = 9;
   localparam int SMOOTH_W    = 3;
   localparam int LOW_W       = 9;
   localparam int HIGH_W      = 10;
   localparam int CENTER_W    = 9;
   localparam int LEVEL_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // at most 2**SMOOTH_W - 1 frames are averaged, so at most this many past terms
   localparam int MAX_TERMS   = (2 ** SMOOTH_W) - 2;
   localparam int SUM_W       = SAMPLE_W + SMOOTH_W;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_MARKER    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_MARKER   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_MARKER = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARKER_LEVEL  = 3'd4;

   // ceil(2^24 / d); exact floor division for sums below 2^20 and d up to 7
   localparam logic [RECIP_W-1:0] RECIP_TABLE [2 ** SMOOTH_W] = '{
      25'd16777216, 25'd16777216, 25'd8388608, 25'd5592406,
      25'd4194304,  25'd3355444,  25'd2796203, 25'd2396746
   };

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  average;
      logic                 segment;
      logic [BIN_OUT_W-1:0] bin_in_segment;
      logic                 last_in_segment;
   } rsp_payload_type;

   typedef struct packed {
      logic [SMOOTH_W-1:0] smoothing;   // already clamped to 1..HISTORY_FRAMES
      logic [RECIP_W-1:0]  recip;
      logic [LOW_W-1:0]    low_marker_bin;
      logic [HIGH_W-1:0]   high_marker_bin;
      logic [CENTER_W-1:0] center_marker_bin;
      logic [LEVEL_W-1:0]  marker_level;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  sample;
      logic                 segment;
      logic [BIN_OUT_W-1:0] bin_in_segment;
      logic                 last_in_segment;
      logic                 marked;
      logic [SMOOTH_W-1:0]  depth;        // number of past frames that enter the sum
   } item_type;

   localparam cfg_type CFG_RESET = '{
      smoothing:         3'd1,
      recip:             RECIP_TABLE[1],
      low_marker_bin:    9'd0,
      high_marker_bin:   10'd512,
      center_marker_bin: 9'd256,
      marker_level:      16'hFFFF
   };

endpackage

// ===== design/sfa_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
interface sfa_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/spectrum_frame_averager.sv =====
// Spectrum frame averager: per-bin moving average over the current and up to
// HISTORY_FRAMES-1 past frames of 2*HALF_BINS bins, with marker-bin override.
// Throughput is one bin per cycle unless the output stalls: each past-frame slot
// has its own history memory, all read at each bin and the oldest rewritten. A
// bin's result passes the queue, memory read, term select, sum, reciprocal multiply
// and output register. History is not swept at reset: a count of completed frames
// keeps unwritten slots out of the sum, so the block takes bins right after reset.
module spectrum_frame_averager import sfa_pkg::*; #(
   parameter int HALF_BINS      = HALF_BINS_DEF,
   parameter int HISTORY_FRAMES = HISTORY_FRAMES_DEF,
   parameter int FIFO_DEPTH     = FIFO_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   sfa_stream_if.sink             req_if,
   sfa_stream_if.source           rsp_if,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int FRAME_BINS = 2 * HALF_BINS;
   localparam int SLOTS      = HISTORY_FRAMES - 1;
   localparam int POS_W      = $clog2(FRAME_BINS);
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ENTRY_W    = $bits(item_type) + POS_W + SLOT_W;

   cfg_type             cfg;
   logic                push_valid;
   logic                push_ready;
   item_type            push_item;
   logic [POS_W-1:0]    push_pos;
   logic [SLOT_W-1:0]   push_slot;
   logic                pop_valid;
   logic                pop_ready;
   logic [ENTRY_W-1:0]  pop_data;
   item_type            pop_item;
   logic [POS_W-1:0]    pop_pos;
   logic [SLOT_W-1:0]   pop_slot;

   sfa_csr #(
      .HISTORY_FRAMES (HISTORY_FRAMES)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   sfa_front #(
      .HALF_BINS      (HALF_BINS),
      .HISTORY_FRAMES (HISTORY_FRAMES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_pos   (push_pos),
      .push_slot  (push_slot),
      .push_ready (push_ready)
   );

   sfa_fifo #(
      .DEPTH  (FIFO_DEPTH),
      .DATA_W (ENTRY_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_pos, push_slot, push_item}),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   assign {pop_pos, pop_slot, pop_item} = pop_data;

   sfa_back #(
      .HALF_BINS      (HALF_BINS),
      .HISTORY_FRAMES (HISTORY_FRAMES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_pos   (pop_pos),
      .pop_slot  (pop_slot),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== design/sfa_csr.sv =====
// Configuration registers with smoothing clamp and reciprocal lookup at write time.
module sfa_csr import sfa_pkg::*; #(
   parameter int HISTORY_FRAMES = HISTORY_FRAMES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output cfg_type                cfg
);

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic [SMOOTH_W-1:0] raw_smoothing;
   logic [SMOOTH_W-1:0] eff_smoothing;

   assign raw_smoothing = csr_write_data[SMOOTH_W-1:0];

   always_comb begin
      if (raw_smoothing == '0) begin
         eff_smoothing = SMOOTH_W'(1);
      end else if (32'(raw_smoothing) > HISTORY_FRAMES) begin
         eff_smoothing = SMOOTH_W'(HISTORY_FRAMES);
      end else begin
         eff_smoothing = raw_smoothing;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SMOOTHING: begin
               cfg_in.smoothing = eff_smoothing;
               cfg_in.recip     = RECIP_TABLE[eff_smoothing];
            end
            CSR_LOW_MARKER:    cfg_in.low_marker_bin    = csr_write_data[LOW_W-1:0];
            CSR_HIGH_MARKER:   cfg_in.high_marker_bin   = csr_write_data[HIGH_W-1:0];
            CSR_CENTER_MARKER: cfg_in.center_marker_bin = csr_write_data[CENTER_W-1:0];
            CSR_MARKER_LEVEL:  cfg_in.marker_level      = csr_write_data[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/sfa_front.sv =====
// Front end: accepts bins, tracks frame position and history slot, classifies each bin.
module sfa_front import sfa_pkg::*; #(
   parameter int HALF_BINS      = HALF_BINS_DEF,
   parameter int HISTORY_FRAMES = HISTORY_FRAMES_DEF,
   localparam int FRAME_BINS    = 2 * HALF_BINS,
   localparam int SLOTS         = HISTORY_FRAMES - 1,
   localparam int POS_W         = $clog2(FRAME_BINS),
   localparam int LOCAL_W       = $clog2(HALF_BINS),
   localparam int SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int FILL_W        = $clog2(SLOTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   sfa_stream_if.sink        req_if,
   input  cfg_type           cfg,
   output logic              push_valid,
   output item_type          push_item,
   output logic [POS_W-1:0]  push_pos,
   output logic [SLOT_W-1:0] push_slot,
   input  logic              push_ready
);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [SLOT_W-1:0]  oldest_ff, oldest_in;
   logic [FILL_W-1:0]  filled_ff, filled_in;   // completed frames since reset, saturating
   logic               accept;
   logic               segment;
   logic [LOCAL_W-1:0] local_bin;
   logic               marked;
   logic [SMOOTH_W-1:0] past_frames;
   logic [SMOOTH_W-1:0] depth;

   assign accept = req_if.valid && push_ready;
   assign req_if.ready = push_ready;

   assign segment   = (pos_ff >= POS_W'(HALF_BINS));
   assign local_bin = segment ? LOCAL_W'(pos_ff - POS_W'(HALF_BINS)) : LOCAL_W'(pos_ff);

   always_comb begin
      if (segment) begin
         marked = (32'(pos_ff) == 32'(cfg.high_marker_bin));
      end else begin
         marked = (32'(local_bin) == 32'(cfg.low_marker_bin)) ||
                  (32'(local_bin) == 32'(cfg.center_marker_bin));
      end
   end

   // history not yet written since reset stays out of the sum
   assign past_frames = cfg.smoothing - SMOOTH_W'(1);
   assign depth = (32'(filled_ff) < 32'(past_frames)) ? SMOOTH_W'(filled_ff) : past_frames;

   always_comb begin
      push_item.sample          = req_if.payload.sample;
      push_item.segment         = segment;
      push_item.bin_in_segment  = BIN_OUT_W'(local_bin);
      push_item.last_in_segment = (local_bin == LOCAL_W'(HALF_BINS - 1));
      push_item.marked          = marked;
      push_item.depth           = depth;
   end

   assign push_valid = req_if.valid;
   assign push_pos   = pos_ff;
   assign push_slot  = oldest_ff;

   always_comb begin
      pos_in    = pos_ff;
      oldest_in = oldest_ff;
      filled_in = filled_ff;
      if (accept) begin
         if (pos_ff == POS_W'(FRAME_BINS - 1)) begin
            pos_in    = '0;
            oldest_in = (oldest_ff == SLOT_W'(SLOTS - 1)) ? '0 : oldest_ff + SLOT_W'(1);
            if (32'(filled_ff) < SLOTS) begin
               filled_in = filled_ff + FILL_W'(1);
            end
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         oldest_ff <= '0;
         filled_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         oldest_ff <= oldest_in;
         filled_ff <= filled_in;
      end
   end

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < FRAME_BINS)
      else $error("bin position left the frame");

   a_slot_fill_bounds: assert property (@(posedge clock) disable iff (reset)
      (32'(oldest_ff) < SLOTS) && (32'(filled_ff) <= SLOTS))
      else $error("history slot or fill count out of range");

endmodule

// ===== design/sfa_fifo.sv =====
// Small queue between front and back end.
module sfa_fifo import sfa_pkg::*; #(
   parameter int DEPTH   = FIFO_DEPTH_DEF,
   parameter int DATA_W  = 8,
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   output logic              push_ready,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data,
   input  logic              pop_ready
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("queue count beyond depth");

endmodule

// ===== design/sfa_back.sv =====
// Back end: history memories, window sum, reciprocal divide, marker override, output register.
module sfa_back import sfa_pkg::*; #(
   parameter int HALF_BINS      = HALF_BINS_DEF,
   parameter int HISTORY_FRAMES = HISTORY_FRAMES_DEF,
   localparam int FRAME_BINS    = 2 * HALF_BINS,
   localparam int SLOTS         = HISTORY_FRAMES - 1,
   localparam int POS_W         = $clog2(FRAME_BINS),
   localparam int SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int FILL_W        = $clog2(SLOTS + 1),
   localparam int PROD_W        = SUM_W + RECIP_W
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              pop_valid,
   input  item_type          pop_item,
   input  logic [POS_W-1:0]  pop_pos,
   input  logic [SLOT_W-1:0] pop_slot,
   output logic              pop_ready,
   sfa_stream_if.source      rsp_if
);

   logic                adv;
   logic [SAMPLE_W-1:0] rd_data [SLOTS];
   logic [FILL_W-1:0]   ages [SLOTS];

   logic                v1_ff, v2_ff, v3_ff, v4_ff, vout_ff;
   item_type            item1_ff, item2_ff, item3_ff, item4_ff;
   logic [SLOT_W-1:0]   slot1_ff;
   logic [SAMPLE_W-1:0] terms_ff [MAX_TERMS];
   logic [SAMPLE_W-1:0] terms_in [MAX_TERMS];
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   rsp_payload_type     rsp_ff, rsp_in;

   // the whole pipeline moves together; it stalls only while a result waits
   assign adv       = !vout_ff || rsp_if.ready;
   assign pop_ready = adv;

   // one history memory per slot: all read at this bin, the oldest one rewritten
   for (genvar j = 0; j < SLOTS; j++) begin : g_slot
      logic [SAMPLE_W-1:0] mem [FRAME_BINS];
      logic [SAMPLE_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (adv) begin
            rd_ff <= mem[pop_pos];
            if (pop_valid && (pop_slot == SLOT_W'(j))) begin
               mem[pop_pos] <= pop_item.sample;
            end
         end
      end

      assign rd_data[j] = rd_ff;

      // frames back from the slot being written; that slot itself is the oldest
      always_comb begin
         if (slot1_ff == SLOT_W'(j)) begin
            ages[j] = FILL_W'(SLOTS);
         end else if (32'(slot1_ff) > j) begin
            ages[j] = FILL_W'(32'(slot1_ff) - j);
         end else begin
            ages[j] = FILL_W'(32'(slot1_ff) + SLOTS - j);
         end
      end
   end

   always_comb begin
      for (int t = 0; t < MAX_TERMS; t++) begin
         terms_in[t] = '0;
         for (int j = 0; j < SLOTS; j++) begin
            if ((32'(ages[j]) == t + 1) && (32'(item1_ff.depth) >= t + 1)) begin
               terms_in[t] = terms_in[t] | rd_data[j];
            end
         end
      end
   end

   always_comb begin
      sum_in = SUM_W'(item2_ff.sample);
      for (int t = 0; t < MAX_TERMS; t++) begin
         sum_in = sum_in + SUM_W'(terms_ff[t]);
      end
   end

   assign prod_in = PROD_W'(sum_ff) * PROD_W'(cfg.recip);

   always_comb begin
      rsp_in.average         = item4_ff.marked ? cfg.marker_level
                                               : prod_ff[RECIP_SHIFT +: SAMPLE_W];
      rsp_in.segment         = item4_ff.segment;
      rsp_in.bin_in_segment  = item4_ff.bin_in_segment;
      rsp_in.last_in_segment = item4_ff.last_in_segment;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item1_ff <= pop_item;
         slot1_ff <= pop_slot;
         item2_ff <= item1_ff;
         terms_ff <= terms_in;
         item3_ff <= item2_ff;
         sum_ff   <= sum_in;
         item4_ff <= item3_ff;
         prod_ff  <= prod_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         vout_ff <= 1'b0;
      end else if (adv) begin
         v1_ff   <= pop_valid;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         vout_ff <= v4_ff;
      end
   end

   assign rsp_if.valid   = vout_ff;
   assign rsp_if.payload = rsp_ff;

   a_depth_below_smoothing: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (32'(item1_ff.depth) < 32'(cfg.smoothing)))
      else $error("past-frame count reaches smoothing");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      (vout_ff && !rsp_if.ready) |=> (vout_ff && $stable(rsp_ff) && $stable(v4_ff)))
      else $error("pipeline moved while result stalled");

endmodule
